### rtl/kdc_pkg.sv
package kdc_pkg;

   // Default display RAM depth and the fixed width of the reported change index.
   localparam int DISPLAY_DEPTH_DEF = 16;
   localparam int CHANGE_INDEX_W    = 4;

   // Bus access kinds and register offsets.
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_READ     = 1'b1;
   localparam logic OFFSET_DATA = 1'b0;
   localparam logic OFFSET_CMD  = 1'b1;

   // Command codes carried in the top three bits of a command byte.
   typedef enum logic [2:0] {
      CMD_MODE          = 3'b000,
      CMD_CLOCK         = 3'b001,
      CMD_READ_SENSOR   = 3'b010,
      CMD_READ_DISPLAY  = 3'b011,
      CMD_WRITE_DISPLAY = 3'b100,
      CMD_BLANK         = 3'b101,
      CMD_CLEAR         = 3'b110,
      CMD_END_INTERRUPT = 3'b111
   } command_type;

   // One bus access as held in the input register.
   typedef struct packed {
      logic        op;
      logic        offset;
      logic [7:0]  write_data;
      logic        keys_enabled;
      logic [7:0]  dip_first;
      logic [7:0]  dip_second;
      logic [47:0] matrix_rows;
      logic [3:0]  pc_key;
   } item_type;

   // One result as held in the output register.
   typedef struct packed {
      logic [7:0]                read_data;
      logic                      lamp_changed;
      logic [CHANGE_INDEX_W-1:0] changed_index;
   } result_type;

endpackage

### rtl/keyboard_display_controller.sv
// Path: an access passes the input register, then the result register, before its
// result is offered; a full result register holds it in the input register.
// Throughput: one access per cycle while the receiver takes results; the decode, the
// display RAM access and the state update all sit between the input and result registers.
// Reset: synchronous, active high; clears all controller state and the display RAM.
module keyboard_display_controller #(
   parameter int DISPLAY_DEPTH = kdc_pkg::DISPLAY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] write_data, [8] keys_enabled, [16:9] dip_first, [24:17] dip_second,
   // [72:25] matrix_rows, [76:73] pc_key, [79:77] zero
   input  logic [79:0] req_tdata,
   // [0] op, [1] offset
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] lamp_changed, [12:9] changed_index, [15:13] zero
   output logic [15:0] rsp_tdata
);

   import kdc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   item_type   req_item;
   result_type result;
   logic       req_fire;
   logic       advance;

   // Unpack the request transfer.
   assign req_item.op           = req_tuser[0];
   assign req_item.offset       = req_tuser[1];
   assign req_item.write_data   = req_tdata[7:0];
   assign req_item.keys_enabled = req_tdata[8];
   assign req_item.dip_first    = req_tdata[16:9];
   assign req_item.dip_second   = req_tdata[24:17];
   assign req_item.matrix_rows  = req_tdata[72:25];
   assign req_item.pc_key       = req_tdata[76:73];

   // An access moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   kdc_ctrl #(
      .DISPLAY_DEPTH (DISPLAY_DEPTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   // Handshake state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff.changed_index, out_result_ff.lamp_changed,
                        out_result_ff.read_data};

`ifndef SYNTHESIS
   // The request side only stalls while the result register is occupied.
   a_stall_needs_full_output : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with an empty result register");

   // The reported change index always addresses the display RAM.
   a_change_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:9] < DISPLAY_DEPTH))
      else $error("changed index beyond display depth");

   // Nothing is offered in the cycle after reset.
   a_empty_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");
`endif

endmodule

### rtl/kdc_sense.sv
module kdc_sense (
   input  logic [2:0]  row_sel,
   input  logic [7:0]  dip_first,
   input  logic [7:0]  dip_second,
   input  logic [47:0] matrix_rows,
   input  logic [3:0]  pc_key,
   output logic [7:0]  sense_data
);

   logic [7:0] raw;

   // Map the selected sensor row onto the switch banks and matrix rows.
   always_comb begin
      case (row_sel)
         3'd0: begin
            raw = dip_first;
         end
         3'd1: begin
            raw = matrix_rows[31:24];
         end
         3'd2: begin
            raw = matrix_rows[47:40];
         end
         3'd3: begin
            raw = matrix_rows[15:8];
         end
         3'd4: begin
            raw = dip_second;
         end
         3'd5: begin
            // Host keys fill the two lowest and the two highest bits of row two.
            raw = matrix_rows[23:16] | {pc_key[3:2], 4'b0000, pc_key[1:0]};
         end
         3'd6: begin
            raw = matrix_rows[39:32];
         end
         default: begin
            raw = matrix_rows[7:0];
         end
      endcase
   end

   // Sensor inputs are active low.
   assign sense_data = ~raw;

endmodule

### rtl/kdc_ctrl.sv
module kdc_ctrl #(
   parameter int DISPLAY_DEPTH = kdc_pkg::DISPLAY_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  kdc_pkg::item_type   item,
   output kdc_pkg::result_type result
);

   import kdc_pkg::*;

   localparam int IDX_W = $clog2(DISPLAY_DEPTH);

   logic [4:0]       mode_word_ff, mode_word_in;
   logic [4:0]       clock_word_ff, clock_word_in;
   logic [2:0]       sensor_row_ff, sensor_row_in;
   logic             sensor_autoinc_ff, sensor_autoinc_in;
   logic [IDX_W-1:0] display_index_ff, display_index_in;
   logic             display_autoinc_ff, display_autoinc_in;
   logic             sensor_selected_ff, sensor_selected_in;
   logic             write_armed_ff, write_armed_in;
   logic             change_flag_ff, change_flag_in;
   logic [IDX_W-1:0] change_index_ff, change_index_in;
   logic [7:0]       memory_ff [DISPLAY_DEPTH];

   logic [IDX_W-1:0] wrap_lut [16];
   logic [IDX_W-1:0] cmd_index;
   logic [IDX_W-1:0] next_index;
   logic [7:0]       mem_rd;
   logic [7:0]       sense_data;
   logic [7:0]       read_data;
   logic             mem_we;
   command_type      cmd;

   // Command addresses reduced modulo the display depth.
   for (genvar i = 0; i < 16; i++) begin : g_wrap
      assign wrap_lut[i] = IDX_W'(i % DISPLAY_DEPTH);
   end

   assign cmd        = command_type'(item.write_data[7:5]);
   assign cmd_index  = wrap_lut[item.write_data[3:0]];
   assign next_index = (display_index_ff == IDX_W'(DISPLAY_DEPTH - 1)) ? '0
                                                                     : display_index_ff + 1'b1;
   assign mem_rd     = memory_ff[display_index_ff];

   kdc_sense u_sense (
      .row_sel     (sensor_row_ff),
      .dip_first   (item.dip_first),
      .dip_second  (item.dip_second),
      .matrix_rows (item.matrix_rows),
      .pc_key      (item.pc_key),
      .sense_data  (sense_data)
   );

   // Decode of one access and the next controller state.
   always_comb begin
      mode_word_in       = mode_word_ff;
      clock_word_in      = clock_word_ff;
      sensor_row_in      = sensor_row_ff;
      sensor_autoinc_in  = sensor_autoinc_ff;
      display_index_in   = display_index_ff;
      display_autoinc_in = display_autoinc_ff;
      sensor_selected_in = sensor_selected_ff;
      write_armed_in     = write_armed_ff;
      change_flag_in     = change_flag_ff;
      change_index_in    = change_index_ff;
      mem_we             = 1'b0;
      read_data          = 8'h00;
      if (step_en) begin
         if (item.op == OP_WRITE) begin
            if (item.offset == OFFSET_CMD) begin
               // Any command disarms display writes before it is decoded.
               write_armed_in = 1'b0;
               case (cmd)
                  CMD_MODE: begin
                     mode_word_in = item.write_data[4:0];
                  end
                  CMD_CLOCK: begin
                     clock_word_in = item.write_data[4:0];
                  end
                  CMD_READ_SENSOR: begin
                     sensor_row_in      = item.write_data[2:0];
                     sensor_autoinc_in  = item.write_data[4];
                     sensor_selected_in = 1'b1;
                  end
                  CMD_READ_DISPLAY: begin
                     display_index_in   = cmd_index;
                     display_autoinc_in = item.write_data[4];
                     sensor_selected_in = 1'b0;
                  end
                  CMD_WRITE_DISPLAY: begin
                     display_index_in   = cmd_index;
                     display_autoinc_in = item.write_data[4];
                     write_armed_in     = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (write_armed_ff) begin
               // Display data write: flag whether the stored byte changes.
               mem_we         = 1'b1;
               change_flag_in = (mem_rd != item.write_data);
               if (mem_rd != item.write_data) begin
                  change_index_in = display_index_ff;
               end
               if (display_autoinc_ff) begin
                  display_index_in = next_index;
               end
            end
         end else if (item.offset == OFFSET_DATA) begin
            if (sensor_selected_ff && item.keys_enabled) begin
               read_data = sense_data;
               if (sensor_autoinc_ff) begin
                  sensor_row_in = sensor_row_ff + 3'd1;
               end
            end else begin
               read_data = mem_rd;
               if (display_autoinc_ff) begin
                  display_index_in = next_index;
               end
            end
         end
      end
   end

   assign result.read_data     = read_data;
   assign result.lamp_changed  = change_flag_in;
   assign result.changed_index = CHANGE_INDEX_W'(change_index_in);

   // Controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_word_ff       <= '0;
         clock_word_ff      <= '0;
         sensor_row_ff      <= '0;
         sensor_autoinc_ff  <= 1'b0;
         display_index_ff   <= '0;
         display_autoinc_ff <= 1'b0;
         sensor_selected_ff <= 1'b0;
         write_armed_ff     <= 1'b0;
         change_flag_ff     <= 1'b0;
         change_index_ff    <= '0;
      end else begin
         mode_word_ff       <= mode_word_in;
         clock_word_ff      <= clock_word_in;
         sensor_row_ff      <= sensor_row_in;
         sensor_autoinc_ff  <= sensor_autoinc_in;
         display_index_ff   <= display_index_in;
         display_autoinc_ff <= display_autoinc_in;
         sensor_selected_ff <= sensor_selected_in;
         write_armed_ff     <= write_armed_in;
         change_flag_ff     <= change_flag_in;
         change_index_ff    <= change_index_in;
      end
   end

   // Display RAM, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DISPLAY_DEPTH; i++) begin
            memory_ff[i] <= 8'h00;
         end
      end else if (mem_we) begin
         memory_ff[display_index_ff] <= item.write_data;
      end
   end

endmodule

### tb/keyboard_display_controller_tb.sv
`timescale 1ns / 1ps

module keyboard_display_controller_tb;

   import kdc_pkg::*;

   localparam int DISPLAY_DEPTH = DISPLAY_DEPTH_DEF;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 500;
   localparam int MAX_PRINTED   = 40;

   // A result for any access that leaves the change flag and index at zero.
   localparam result_type NO_CHANGE = '0;

   // One row of the directed table; typed rows carry their expected result.
   typedef struct packed {
      logic       op;
      logic       offset;
      logic [7:0] data;
      logic       keys;
      logic       typed;
      result_type want;
   } directed_row_type;

   // One planned access, in the order it will be transferred.
   typedef struct {
      item_type   acc;
      bit         typed;
      result_type want;
   } planned_access_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_kind_type;

   // Directed accesses: reset values, extremes, every command and the
   // special cases of disarmed writes, unchanged bytes and index wrapping.
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b1, NO_CHANGE},
      '{OP_READ,  OFFSET_CMD,  8'hFF, 1'b1, 1'b1, NO_CHANGE},
      '{OP_WRITE, OFFSET_DATA, 8'hFF, 1'b0, 1'b1, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_MODE, 5'h1F}, 1'b0, 1'b1, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_CLOCK, 5'h1F}, 1'b0, 1'b1, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_WRITE_DISPLAY, 5'h1F}, 1'b0, 1'b1, NO_CHANGE},
      '{OP_WRITE, OFFSET_DATA, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b1, 4'd15}},
      '{OP_WRITE, OFFSET_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 4'd15}},
      '{OP_WRITE, OFFSET_DATA, 8'hA5, 1'b1, 1'b1, '{8'h00, 1'b1, 4'd1}},
      '{OP_WRITE, OFFSET_CMD,  {CMD_BLANK, 5'h00}, 1'b0, 1'b0, NO_CHANGE},
      '{OP_WRITE, OFFSET_DATA, 8'h12, 1'b0, 1'b0, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_READ_DISPLAY, 5'h1F}, 1'b0, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_READ_SENSOR, 5'h17}, 1'b0, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b0, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_READ,  OFFSET_DATA, 8'h00, 1'b1, 1'b0, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_CLEAR, 5'h1F}, 1'b0, 1'b0, NO_CHANGE},
      '{OP_WRITE, OFFSET_CMD,  {CMD_END_INTERRUPT, 5'h1F}, 1'b0, 1'b0, NO_CHANGE}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // Controller state as the predictor sees it.
   logic [4:0]  kd_mode;
   logic [4:0]  kd_clock;
   logic [2:0]  sense_row;
   logic        sense_autoinc;
   logic        sense_selected;
   logic [3:0]  disp_index;
   logic        disp_autoinc;
   logic        disp_armed;
   logic [7:0]  disp_ram [DISPLAY_DEPTH];
   logic        lamp_flag;
   logic [3:0]  lamp_index;

   planned_access_type access_plan [$];
   result_type         pending_results [$];

   int          accepted_count = 0;
   int          result_count = 0;
   int          data_reads = 0;
   int          data_writes = 0;
   int          mismatch_count = 0;

   stall_kind_type stall_kind = STALL_NONE;
   int             stall_left = 0;
   logic [7:0]     stall_pattern = 8'h01;

   keyboard_display_controller #(
      .DISPLAY_DEPTH(DISPLAY_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Display addresses wrap at the RAM depth.
   function automatic logic [3:0] wrap_display(input int addr);
      return 4'(addr % DISPLAY_DEPTH);
   endfunction

   // Works out the result of one bus access and updates the controller state.
   function automatic result_type predict_bus_access(input item_type acc);
      result_type r;
      logic [7:0] raw;
      logic [3:0] slot;
      r = NO_CHANGE;
      raw = '0;
      if (acc.op == OP_WRITE && acc.offset == OFFSET_CMD) begin
         // Every command disarms display writes before it is decoded.
         disp_armed = 1'b0;
         case (command_type'(acc.write_data[7:5]))
            CMD_MODE: kd_mode = acc.write_data[4:0];
            CMD_CLOCK: kd_clock = acc.write_data[4:0];
            CMD_READ_SENSOR: begin
               sense_row      = acc.write_data[2:0];
               sense_autoinc  = acc.write_data[4];
               sense_selected = 1'b1;
            end
            CMD_READ_DISPLAY: begin
               disp_index     = wrap_display(int'(acc.write_data[3:0]));
               disp_autoinc   = acc.write_data[4];
               sense_selected = 1'b0;
            end
            CMD_WRITE_DISPLAY: begin
               disp_index   = wrap_display(int'(acc.write_data[3:0]));
               disp_autoinc = acc.write_data[4];
               disp_armed   = 1'b1;
            end
            default: ;
         endcase
      end else if (acc.op == OP_WRITE) begin
         // A data write only lands while display writes are armed.
         if (disp_armed) begin
            slot = disp_index;
            lamp_flag = (disp_ram[slot] != acc.write_data);
            if (lamp_flag) begin
               lamp_index = slot;
            end
            disp_ram[slot] = acc.write_data;
            if (disp_autoinc) begin
               disp_index = wrap_display(int'(slot) + 1);
            end
         end
      end else if (acc.offset == OFFSET_DATA) begin
         if (sense_selected && acc.keys_enabled) begin
            // Sensor rows are scrambled across the matrix and read inverted.
            case (sense_row)
               3'd0: raw = acc.dip_first;
               3'd1: raw = acc.matrix_rows[24 +: 8];
               3'd2: raw = acc.matrix_rows[40 +: 8];
               3'd3: raw = acc.matrix_rows[8 +: 8];
               3'd4: raw = acc.dip_second;
               3'd5: raw = acc.matrix_rows[16 +: 8]
                           | {acc.pc_key[3:2], 4'b0000, acc.pc_key[1:0]};
               3'd6: raw = acc.matrix_rows[32 +: 8];
               default: raw = acc.matrix_rows[0 +: 8];
            endcase
            r.read_data = ~raw;
            if (sense_autoinc) begin
               sense_row = sense_row + 3'd1;
            end
         end else begin
            r.read_data = disp_ram[disp_index];
            if (disp_autoinc) begin
               disp_index = wrap_display(int'(disp_index) + 1);
            end
         end
      end
      r.lamp_changed  = lamp_flag;
      r.changed_index = lamp_index;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("ERROR at %0t ns, result %0d: %s", $time, result_count, msg);
      end
   endtask

   // Adds one access to the plan; directed rows use fixed extreme pin values.
   task automatic plan_access(input logic op, input logic offset, input logic [7:0] data,
                              input logic keys, input bit directed, input bit typed,
                              input result_type want);
      planned_access_type e;
      e.acc.op           = op;
      e.acc.offset       = offset;
      e.acc.write_data   = data;
      e.acc.keys_enabled = keys;
      if (directed) begin
         e.acc.dip_first   = 8'h00;
         e.acc.dip_second  = 8'hFF;
         e.acc.matrix_rows = 48'hA5_7E_81_00_FF_00;
         e.acc.pc_key      = 4'hF;
      end else begin
         e.acc.dip_first   = 8'($urandom);
         e.acc.dip_second  = 8'($urandom);
         e.acc.matrix_rows = {16'($urandom), 32'($urandom)};
         e.acc.pc_key      = 4'($urandom);
      end
      e.typed = typed;
      e.want  = want;
      access_plan.push_back(e);
   endtask

   initial begin
      kd_mode        = '0;
      kd_clock       = '0;
      sense_row      = '0;
      sense_autoinc  = 1'b0;
      sense_selected = 1'b0;
      disp_index     = '0;
      disp_autoinc   = 1'b0;
      disp_armed     = 1'b0;
      lamp_flag      = 1'b0;
      lamp_index     = '0;
      for (int i = 0; i < DISPLAY_DEPTH; i++) begin
         disp_ram[i] = '0;
      end
   end

   // Builds the plan, then sends it in bursts with random gaps between them.
   initial begin
      int run_len;
      int gap;
      int burst_left;
      burst_left = 0;
      foreach (DIRECTED_TABLE[i]) begin
         plan_access(DIRECTED_TABLE[i].op, DIRECTED_TABLE[i].offset, DIRECTED_TABLE[i].data,
                     DIRECTED_TABLE[i].keys, 1'b1, DIRECTED_TABLE[i].typed,
                     DIRECTED_TABLE[i].want);
      end

      // Mostly well-formed command-then-data runs, with some noise and
      // runs whose arming command is cancelled by a second command.
      while (access_plan.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         run_len = $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               plan_access(OP_WRITE, OFFSET_CMD, {CMD_WRITE_DISPLAY, 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               repeat (run_len) begin
                  plan_access(OP_WRITE, OFFSET_DATA,
                              $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                              1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               end
            end
            3, 4: begin
               plan_access(OP_WRITE, OFFSET_CMD, {CMD_READ_DISPLAY, 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               repeat (run_len) begin
                  plan_access(OP_READ, OFFSET_DATA, 8'($urandom), 1'($urandom),
                              1'b0, 1'b0, NO_CHANGE);
               end
            end
            5, 6: begin
               plan_access(OP_WRITE, OFFSET_CMD, {CMD_READ_SENSOR, 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               repeat (run_len) begin
                  plan_access(OP_READ, OFFSET_DATA, 8'($urandom),
                              $urandom_range(0, 3) != 0, 1'b0, 1'b0, NO_CHANGE);
               end
            end
            7: begin
               plan_access(OP_WRITE, OFFSET_CMD,
                           {command_type'($urandom_range(0, 7)), 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
            end
            8: begin
               repeat (run_len) begin
                  plan_access(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                              1'b0, 1'b0, NO_CHANGE);
               end
            end
            default: begin
               plan_access(OP_WRITE, OFFSET_CMD, {CMD_WRITE_DISPLAY, 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               plan_access(OP_WRITE, OFFSET_CMD,
                           {command_type'($urandom_range(0, 7)), 5'($urandom)},
                           1'($urandom), 1'b0, 1'b0, NO_CHANGE);
               repeat (run_len) begin
                  plan_access(OP_WRITE, OFFSET_DATA, 8'($urandom), 1'($urandom),
                              1'b0, 1'b0, NO_CHANGE);
               end
            end
         endcase
      end

      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end

      foreach (access_plan[i]) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tuser  <= {access_plan[i].acc.offset, access_plan[i].acc.op};
         req_tdata  <= {3'b000, access_plan[i].acc.pc_key, access_plan[i].acc.matrix_rows,
                        access_plan[i].acc.dip_second, access_plan[i].acc.dip_first,
                        access_plan[i].acc.keys_enabled, access_plan[i].acc.write_data};
         @(posedge clock);
         while (!req_tready) begin
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then wait for any stray result to pass the input and result registers.
      while (pending_results.size() != 0 || accepted_count < access_plan.size()) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);

      $display("Run covered %0d accesses (%0d data reads, %0d data writes), %0d results.",
               accepted_count, data_reads, data_writes, result_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver readiness: always ready, random stalls, or a rotating pattern.
   always @(posedge clock) begin
      case (stall_kind)
         STALL_NONE: rsp_tready <= 1'b1;
         STALL_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= stall_pattern[0];
      endcase
      if (stall_left == 0) begin
         stall_kind    <= stall_kind_type'($urandom_range(0, 2));
         stall_left    <= $urandom_range(20, 120);
         stall_pattern <= 8'($urandom) | 8'h01;
      end else begin
         stall_left    <= stall_left - 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      end
   end

   // Each transfer into the block queues its expected result.
   always @(posedge clock) begin
      item_type   acc;
      result_type want;
      if (!reset && req_tvalid && req_tready) begin
         acc.op           = req_tuser[0];
         acc.offset       = req_tuser[1];
         acc.write_data   = req_tdata[7:0];
         acc.keys_enabled = req_tdata[8];
         acc.dip_first    = req_tdata[16:9];
         acc.dip_second   = req_tdata[24:17];
         acc.matrix_rows  = req_tdata[72:25];
         acc.pc_key       = req_tdata[76:73];
         want = predict_bus_access(acc);
         if (access_plan[accepted_count].typed) begin
            want = access_plan[accepted_count].want;
         end
         pending_results.push_back(want);
         if (acc.offset == OFFSET_DATA) begin
            if (acc.op == OP_READ) begin
               data_reads++;
            end else begin
               data_writes++;
            end
         end
         accepted_count++;
      end
   end

   // Each result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no access waiting, data 0x%04h",
                                      rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] != want.read_data) begin
               report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                         rsp_tdata[7:0], want.read_data));
            end
            if (rsp_tdata[8] != want.lamp_changed) begin
               report_mismatch($sformatf("lamp_changed %0b, expected %0b",
                                         rsp_tdata[8], want.lamp_changed));
            end
            if (rsp_tdata[12:9] != want.changed_index) begin
               report_mismatch($sformatf("changed_index %0d, expected %0d",
                                         rsp_tdata[12:9], want.changed_index));
            end
         end
      end
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #200_000;
      $display("Timeout with %0d results still outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
